/* src/fqkp_pkg.sv */
package fqkp_pkg;

  // Item kinds
  typedef enum logic [2:0] {
    KIND_PRELOAD = 3'd0,
    KIND_ADD     = 3'd1,
    KIND_REMOVE  = 3'd2,
    KIND_INC     = 3'd3,
    KIND_DEC     = 3'd4,
    KIND_PICK    = 3'd5
  } kind_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BUSY        = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_STACK_EMPTY = 3'd3,
    ST_STACK_FULL  = 3'd4,
    ST_AT_QUOTA    = 3'd5,
    ST_HELD_ZERO   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_APPLY,
    S_SWEEP_RD,
    S_SWEEP_WR,
    S_SCAN_RD,
    S_SCAN_EVAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] slot;
    logic [7:0] quota_value;
    logic [7:0] ready_mask;
  } in_t;

  typedef struct packed {
    logic       chosen_valid;
    logic [2:0] chosen_slot;
    status_t    status;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic decode;
    logic apply;
    logic sweep_rd;
    logic sweep_wr;
    logic scan_rd;
    logic scan_eval;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] kind;
    logic       pre_fail;
    logic       sweep_last;
    logic       scan_last;
  } dp_stat_t;

endpackage

/* src/fqkp_ram.sv */
module fqkp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/fqkp_datapath.sv */
module fqkp_datapath import fqkp_pkg::*; #(
  parameter int SLOTS       = 8,
  parameter int STACK_DEPTH = 8,
  parameter int QUOTA_BITS  = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  in_t      item_in,
  input  cmd_t     cmd,
  output dp_stat_t stat,
  output out_t     result
);

  localparam int SW     = $clog2(SLOTS);
  localparam int AW     = $clog2(SLOTS + 1);
  localparam int SAW    = $clog2(STACK_DEPTH);
  localparam int DW     = $clog2(STACK_DEPTH + 1);
  localparam int QB     = QUOTA_BITS;
  localparam int PICK_N = (SLOTS < 8) ? SLOTS : 8;

  typedef struct packed {
    logic [QB-1:0] quota;
    logic [QB-1:0] held;
    logic [SW-1:0] order;
  } rec_t;

  in_t             item;
  logic [SLOTS-1:0] in_use;
  logic [DW-1:0]   free_depth;
  logic [AW-1:0]   active_count;
  logic [SW-1:0]   idx;
  logic [SW-1:0]   rem_order;
  logic [SW-1:0]   best_rank;
  logic [QB-1:0]   best_diff;
  out_t            res;

  logic [SW-1:0]   slot_idx;
  logic            slot_ok;
  logic            occ;
  logic            stack_full;
  logic            stack_empty;
  status_t         pre_status;
  logic            at_quota;
  logic            held_zero;
  logic            sweep_last;
  logic            scan_last;
  logic            cand;
  logic            better;
  logic [QB-1:0]   diff;

  logic            rec_we;
  logic [SW-1:0]   rec_waddr;
  logic [SW-1:0]   rec_raddr;
  rec_t            rec_wdata;
  rec_t            rec_rdata;
  logic            stk_we;
  logic [SAW-1:0]  stk_waddr;
  logic [SAW-1:0]  stk_raddr;
  logic [QB-1:0]   stk_wdata;
  logic [QB-1:0]   stk_rdata;

  assign slot_idx    = SW'(item.slot);
  assign slot_ok     = (32'(item.slot) < SLOTS);
  assign occ         = slot_ok && in_use[slot_idx];
  assign stack_full  = (free_depth >= DW'(STACK_DEPTH));
  assign stack_empty = (free_depth == '0);
  assign at_quota    = (rec_rdata.held >= rec_rdata.quota);
  assign held_zero   = (rec_rdata.held == '0);
  assign sweep_last  = (idx == SW'(SLOTS - 1));
  assign scan_last   = (idx == SW'(PICK_N - 1));

  always_comb begin
    pre_status = ST_OK;
    unique case (item.kind) inside
      KIND_PRELOAD: if (stack_full) pre_status = ST_STACK_FULL;
      KIND_ADD: begin
        if (!slot_ok)            pre_status = ST_EMPTY;
        else if (in_use[slot_idx]) pre_status = ST_BUSY;
        else if (stack_empty)    pre_status = ST_STACK_EMPTY;
      end
      KIND_REMOVE: begin
        if (!occ)             pre_status = ST_EMPTY;
        else if (stack_full)  pre_status = ST_STACK_FULL;
      end
      KIND_INC, KIND_DEC: if (!occ) pre_status = ST_EMPTY;
      default: pre_status = ST_OK;
    endcase
  end

  assign stat.kind       = item.kind;
  assign stat.pre_fail   = (pre_status != ST_OK);
  assign stat.sweep_last = sweep_last;
  assign stat.scan_last  = scan_last;

  // Pick candidate: occupied, ready and below its quota
  assign diff   = rec_rdata.quota - rec_rdata.held;
  assign cand   = in_use[idx] && item.ready_mask[3'(idx)] && !at_quota;
  assign better = cand && ((diff > best_diff) ||
                  (res.chosen_valid && diff == best_diff && rec_rdata.order < best_rank));

  assign rec_raddr = (cmd.sweep_rd || cmd.scan_rd) ? idx : slot_idx;
  assign stk_raddr = SAW'(free_depth - DW'(1));

  always_comb begin
    rec_we    = 1'b0;
    rec_waddr = slot_idx;
    rec_wdata = rec_rdata;
    stk_we    = 1'b0;
    stk_waddr = SAW'(free_depth);
    stk_wdata = QB'(item.quota_value);
    if (cmd.decode && item.kind == KIND_PRELOAD && !stack_full) begin
      stk_we = 1'b1;
    end
    if (cmd.apply) begin
      case (item.kind)
        KIND_ADD: begin
          rec_we          = 1'b1;
          rec_wdata.quota = stk_rdata;
          rec_wdata.held  = '0;
          rec_wdata.order = SW'(active_count);
        end
        KIND_REMOVE: begin
          stk_we    = 1'b1;
          stk_wdata = rec_rdata.quota;
        end
        KIND_INC: begin
          rec_we         = !at_quota;
          rec_wdata.held = rec_rdata.held + QB'(1);
        end
        KIND_DEC: begin
          rec_we         = !held_zero;
          rec_wdata.held = rec_rdata.held - QB'(1);
        end
        default: rec_we = 1'b0;
      endcase
    end
    if (cmd.sweep_wr) begin
      rec_waddr       = idx;
      rec_we          = in_use[idx] && (rec_rdata.order > rem_order);
      rec_wdata.order = rec_rdata.order - SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use       <= '0;
      free_depth   <= '0;
      active_count <= '0;
    end else begin
      if (cmd.load) begin
        item      <= item_in;
        res       <= '0;
        best_diff <= '0;
        best_rank <= '0;
        idx       <= '0;
      end
      if (cmd.decode) begin
        res.status <= pre_status;
        if (item.kind == KIND_PRELOAD && !stack_full) begin
          free_depth <= free_depth + DW'(1);
        end
      end
      if (cmd.apply) begin
        case (item.kind)
          KIND_ADD: begin
            free_depth       <= free_depth - DW'(1);
            active_count     <= active_count + AW'(1);
            in_use[slot_idx] <= 1'b1;
          end
          KIND_REMOVE: begin
            free_depth <= free_depth + DW'(1);
            rem_order  <= rec_rdata.order;
          end
          KIND_INC: if (at_quota)  res.status <= ST_AT_QUOTA;
          KIND_DEC: if (held_zero) res.status <= ST_HELD_ZERO;
          default: res.status <= res.status;
        endcase
      end
      if (cmd.sweep_wr) begin
        if (sweep_last) begin
          in_use[slot_idx] <= 1'b0;
          active_count     <= active_count - AW'(1);
        end else begin
          idx <= idx + SW'(1);
        end
      end
      if (cmd.scan_eval) begin
        if (better) begin
          res.chosen_valid <= 1'b1;
          res.chosen_slot  <= 3'(idx);
          best_diff        <= diff;
          best_rank        <= rec_rdata.order;
        end
        if (!scan_last) begin
          idx <= idx + SW'(1);
        end
      end
    end
  end

  assign result = res;

  fqkp_ram #(.WIDTH(2 * QB + SW), .DEPTH(SLOTS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  fqkp_ram #(.WIDTH(QB), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

/* src/fqkp_ctrl.sv */
module fqkp_ctrl import fqkp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output cmd_t     cmd,
  output logic     busy,
  output logic     done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_DECODE;
      S_DECODE: begin
        if (stat.pre_fail) begin
          state_next = S_DONE;
        end else begin
          unique case (stat.kind) inside
            KIND_ADD, KIND_REMOVE, KIND_INC, KIND_DEC: state_next = S_APPLY;
            KIND_PICK: state_next = S_SCAN_RD;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_APPLY:     state_next = (stat.kind == KIND_REMOVE) ? S_SWEEP_RD : S_DONE;
      S_SWEEP_RD:  state_next = S_SWEEP_WR;
      S_SWEEP_WR:  state_next = stat.sweep_last ? S_DONE : S_SWEEP_RD;
      S_SCAN_RD:   state_next = S_SCAN_EVAL;
      S_SCAN_EVAL: state_next = stat.scan_last ? S_DONE : S_SCAN_RD;
      S_DONE:      state_next = start ? S_DECODE : S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy          = !(state == S_IDLE || state == S_DONE);
    done          = (state == S_DONE);
    cmd.load      = start && !busy;
    cmd.decode    = (state == S_DECODE);
    cmd.apply     = (state == S_APPLY);
    cmd.sweep_rd  = (state == S_SWEEP_RD);
    cmd.sweep_wr  = (state == S_SWEEP_WR);
    cmd.scan_rd   = (state == S_SCAN_RD);
    cmd.scan_eval = (state == S_SCAN_EVAL);
  end

endmodule

/* src/fixed_quota_kernel_picker.sv */
// Kernel slot table with fixed core quotas and a free-quota stack. Issue a
// transaction by raising start with item while busy is low; exactly one result
// follows on result, marked by done for a single cycle, and it must be taken
// then: there is no way to hold it off. A new transaction may be issued in the
// same cycle as done. Path from accept to done: preload, ignored kinds and
// transactions failing a slot or stack check pass decode only; add, increment
// and decrement pass decode and apply, also at the quota or at zero; remove
// then sweeps every slot, pick scans min(SLOTS,8) slots after decode. The
// longer cases are set by the slot record memory, which has one registered
// read port and is visited read-then-update one slot at a time to renumber
// add order after a remove, or to compare slots during a pick. No clearing
// pass is needed after reset.
module fixed_quota_kernel_picker import fqkp_pkg::*; #(
  parameter int SLOTS       = 8,
  parameter int STACK_DEPTH = 8,
  parameter int QUOTA_BITS  = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  in_t  item,
  output logic busy,
  output logic done,
  output out_t result
);

  cmd_t     cmd;
  dp_stat_t stat;

  // Sequence each transaction: decode, then apply (and a sweep for a remove), a slot scan or done
  fqkp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Hold the slot table, free stack and result registers
  fqkp_datapath #(
    .SLOTS       (SLOTS),
    .STACK_DEPTH (STACK_DEPTH),
    .QUOTA_BITS  (QUOTA_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .item_in (item),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

endmodule

/* src/fqkp_checker.sv */
module fqkp_checker import fqkp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input out_t result
);

  // An accepted transaction always raises busy in the next cycle
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accept did not raise busy");

  // A result strobe lasts a single cycle
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // A found kernel only comes with an ok status
  assert property (@(posedge clk) disable iff (rst)
    (done && result.chosen_valid) |-> (result.status == ST_OK))
    else $error("chosen kernel with error status");

  // No kernel chosen means slot zero
  assert property (@(posedge clk) disable iff (rst)
    (done && !result.chosen_valid) |-> (result.chosen_slot == 3'd0))
    else $error("nonzero slot without a choice");

endmodule

bind fixed_quota_kernel_picker fqkp_checker u_fqkp_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

/* tb/fqkp_checker.sv */
module fqkp_scoreboard import fqkp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  in_t  item,
  input  logic done,
  input  out_t result,
  output int   fail_count,
  output int   pending
);

  localparam int SLOTS       = 8;
  localparam int STACK_DEPTH = 8;

  // Own copy of the slot table and the free-quota stack
  logic       in_use  [SLOTS];
  logic [7:0] quota   [SLOTS];
  logic [7:0] held    [SLOTS];
  logic [2:0] rank    [SLOTS];
  logic [3:0] active_n;
  logic [7:0] free_q  [STACK_DEPTH];
  logic [3:0] free_n;

  out_t due_outcomes [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Apply one transaction to the table and return the outcome it must produce
  function automatic out_t slot_table_step(input in_t it);
    out_t       r;
    logic [7:0] best;
    logic [7:0] diff;
    logic [2:0] best_rank;
    int         i;
    int         s;
    r         = '0;
    r.status  = ST_OK;
    best      = '0;
    best_rank = '0;
    s         = it.slot;
    case (it.kind)
      KIND_PRELOAD: begin
        if (free_n >= STACK_DEPTH) begin
          r.status = ST_STACK_FULL;
        end else begin
          free_q[free_n[2:0]] = it.quota_value;
          free_n++;
        end
      end
      KIND_ADD: begin
        if (in_use[s]) begin
          r.status = ST_BUSY;
        end else if (free_n == 0) begin
          r.status = ST_STACK_EMPTY;
        end else begin
          free_n--;
          quota[s]  = free_q[free_n[2:0]];
          held[s]   = '0;
          in_use[s] = 1'b1;
          rank[s]   = active_n[2:0];
          active_n++;
        end
      end
      KIND_REMOVE: begin
        if (!in_use[s]) begin
          r.status = ST_EMPTY;
        end else if (free_n >= STACK_DEPTH) begin
          r.status = ST_STACK_FULL;
        end else begin
          free_q[free_n[2:0]] = quota[s];
          free_n++;
          // close the gap in add order left by the departing kernel
          for (i = 0; i < SLOTS; i++) begin
            if (in_use[i] && rank[i] > rank[s]) rank[i]--;
          end
          in_use[s] = 1'b0;
          rank[s]   = '0;
          if (active_n > 0) active_n--;
        end
      end
      KIND_INC: begin
        if (!in_use[s]) begin
          r.status = ST_EMPTY;
        end else if (held[s] >= quota[s]) begin
          r.status = ST_AT_QUOTA;
        end else begin
          held[s]++;
        end
      end
      KIND_DEC: begin
        if (!in_use[s]) begin
          r.status = ST_EMPTY;
        end else if (held[s] == 0) begin
          r.status = ST_HELD_ZERO;
        end else begin
          held[s]--;
        end
      end
      KIND_PICK: begin
        for (i = 0; i < SLOTS; i++) begin
          if (in_use[i] && it.ready_mask[i] && held[i] < quota[i]) begin
            diff = quota[i] - held[i];
            if (diff > best || (r.chosen_valid && diff == best && rank[i] < best_rank)) begin
              best           = diff;
              best_rank      = rank[i];
              r.chosen_slot  = 3'(i);
              r.chosen_valid = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        in_use[i] = 1'b0;
        quota[i]  = '0;
        held[i]   = '0;
        rank[i]   = '0;
      end
      for (int i = 0; i < STACK_DEPTH; i++) free_q[i] = '0;
      active_n = '0;
      free_n   = '0;
      due_outcomes.delete();
    end else begin
      // a result leaves before a new transaction joins, as both may share an edge
      if (done) begin
        if (due_outcomes.size() == 0) begin
          flag_mismatch("result with no transaction outstanding");
        end else begin
          want = due_outcomes.pop_front();
          if (result.chosen_valid !== want.chosen_valid)
            flag_mismatch($sformatf("chosen_valid got %0d expected %0d",
                                    result.chosen_valid, want.chosen_valid));
          if (result.chosen_slot !== want.chosen_slot)
            flag_mismatch($sformatf("chosen_slot got %0d expected %0d",
                                    result.chosen_slot, want.chosen_slot));
          if (result.status !== want.status)
            flag_mismatch($sformatf("status got %0d expected %0d",
                                    result.status, want.status));
        end
      end
      // queue the predicted outcome at the tail
      if (start && !busy) due_outcomes.insert(due_outcomes.size(), slot_table_step(item));
    end
    pending <= due_outcomes.size();
  end

endmodule

/* tb/tb_fixed_quota_kernel_picker.sv */
module tb_fixed_quota_kernel_picker;
  import fqkp_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  // no idling over the final stretch of the run
  localparam int CALM_TAIL    = 150;
  // slowest transaction is a remove, which sweeps every slot, plus the longest rest: leave ample room
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;

  // kinds the block does not know: it must answer them with an all-zero result
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  in_t  item  = '0;
  logic busy;
  logic done;
  out_t result;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;

  always #4 clk = ~clk;

  fixed_quota_kernel_picker i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // Watch both channels, predict each transaction's outcome and compare
  fqkp_scoreboard u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic in_t make_item(input logic [2:0] kind, input logic [2:0] slot,
                                    input logic [7:0] qv, input logic [7:0] mask);
    in_t it;
    it.kind        = kind;
    it.slot        = slot;
    it.quota_value = qv;
    it.ready_mask  = mask;
    return it;
  endfunction

  // Weight the kinds so the table fills, drains and saturates often; keep most
  // quotas small so held counts reach their quota and picks see ties.
  function automatic in_t random_item();
    in_t it;
    int  roll;
    roll = $urandom_range(0, 99);
    if (roll < 15)      it.kind = KIND_PRELOAD;
    else if (roll < 33) it.kind = KIND_ADD;
    else if (roll < 45) it.kind = KIND_REMOVE;
    else if (roll < 65) it.kind = KIND_INC;
    else if (roll < 77) it.kind = KIND_DEC;
    else if (roll < 97) it.kind = KIND_PICK;
    else                it.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
    it.slot = 3'($urandom_range(0, 7));
    roll = $urandom_range(0, 9);
    if (roll < 5)       it.quota_value = 8'($urandom_range(0, 4));
    else if (roll == 5) it.quota_value = 8'h00;
    else if (roll == 6) it.quota_value = 8'hff;
    else                it.quota_value = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 4);
    if (roll == 0)      it.ready_mask = 8'hff;
    else if (roll == 1) it.ready_mask = 8'h01 << $urandom_range(0, 7);
    else                it.ready_mask = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Hold start and the item until the block takes the transaction; leave start
  // high on return so back-to-back transactions need no new rising edge on it.
  task automatic issue(input in_t it);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start for a burst of cycles, with junk on the item lines meanwhile
  task automatic rest(input int cycles);
    start <= 1'b0;
    item  <= random_item();
    repeat (cycles) @(posedge clk);
  endtask

  // Watchdog: end the run if no transaction and no result moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_t it;
    int  sent;
    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty table and empty stack first
    issue(make_item(KIND_PICK,   3'd0, 8'h00, 8'hff)); // no candidate at all
    issue(make_item(KIND_ADD,    3'd0, 8'h00, 8'h00)); // stack empty
    issue(make_item(KIND_REMOVE, 3'd2, 8'h00, 8'h00)); // slot empty
    issue(make_item(KIND_INC,    3'd4, 8'h00, 8'h00)); // slot empty
    issue(make_item(KIND_DEC,    3'd6, 8'h00, 8'h00)); // slot empty
    // Fill the stack, extremes of the quota among the values, then overfill it
    issue(make_item(KIND_PRELOAD, 3'd7, 8'hff, 8'hff));
    issue(make_item(KIND_PRELOAD, 3'd0, 8'h00, 8'h00));
    issue(make_item(KIND_PRELOAD, 3'd0, 8'h01, 8'h00));
    issue(make_item(KIND_PRELOAD, 3'd0, 8'h80, 8'h00));
    issue(make_item(KIND_PRELOAD, 3'd0, 8'h07, 8'h00));
    issue(make_item(KIND_PRELOAD, 3'd0, 8'h03, 8'h00));
    issue(make_item(KIND_PRELOAD, 3'd0, 8'hc8, 8'h00));
    issue(make_item(KIND_PRELOAD, 3'd0, 8'h01, 8'h00));
    issue(make_item(KIND_PRELOAD, 3'd0, 8'h05, 8'h00)); // stack full
    // Occupy a slot, then try it again and try to give its quota back to a full stack
    issue(make_item(KIND_ADD,     3'd0, 8'h00, 8'h00)); // quota 1
    issue(make_item(KIND_ADD,     3'd0, 8'h00, 8'h00)); // slot busy
    issue(make_item(KIND_PRELOAD, 3'd0, 8'h09, 8'h00));
    issue(make_item(KIND_REMOVE,  3'd0, 8'h00, 8'h00)); // stack full on remove
    issue(make_item(KIND_ADD,     3'd7, 8'h00, 8'h00));
    issue(make_item(KIND_ADD,     3'd3, 8'h00, 8'h00));
    issue(make_item(KIND_INC,     3'd0, 8'h00, 8'h00));
    issue(make_item(KIND_INC,     3'd0, 8'h00, 8'h00)); // held at quota
    issue(make_item(KIND_DEC,     3'd7, 8'h00, 8'h00)); // held already zero
    issue(make_item(KIND_PICK,    3'd0, 8'h00, 8'hff)); // slot 0 is full, others compete
    issue(make_item(KIND_REMOVE,  3'd7, 8'h00, 8'h00)); // renumber add order
    issue(make_item(KIND_PICK,    3'd0, 8'h00, 8'h00)); // nothing ready
    issue(make_item(KIND_SPARE_A, 3'd7, 8'hff, 8'hff));
    issue(make_item(KIND_SPARE_B, 3'd5, 8'h55, 8'haa));

    // Random part; ignored kinds do not advance the count
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
        rest($urandom_range(1, 7));
      it = random_item();
      issue(it);
      if (it.kind <= KIND_PICK) sent++;
    end

    // Drain: let the pending count catch up with the last transaction first
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
